// File: rtl/ssrq_pkg.sv
`default_nettype none

package ssrq_pkg;

  localparam int SLOT_W = 12;
  localparam int CAP_W  = 13;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_TAKE    = 2'd1,
    OP_MARK    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RC_DONE           = 3'd0,
    RC_FULL           = 3'd1,
    RC_TAIL_WRITTEN   = 3'd2,
    RC_EMPTY          = 3'd3,
    RC_HEAD_UNWRITTEN = 3'd4
  } rc_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ssrq_if.sv
`default_nettype none

interface ssrq_req_if import ssrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [SLOT_W-1:0] slot_index;
  logic              written_value;

  modport source (output valid, op, slot_index, written_value, input ready);
  modport sink   (input valid, op, slot_index, written_value, output ready);
endinterface

interface ssrq_rsp_if import ssrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        result_code;
  logic [SLOT_W-1:0] granted_slot;

  modport source (output valid, result_code, granted_slot, input ready);
  modport sink   (input valid, result_code, granted_slot, output ready);
endinterface

`default_nettype wire

// File: rtl/ssrq_ram.sv
`default_nettype none

module ssrq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/slot_status_ring_queue.sv
// Slot status ring queue.
// Requests arrive on in_req (valid/ready); each transfer carries op, slot_index
// and written_value. Every request produces exactly one result on out_rsp
// (valid/ready) with result_code and granted_slot. Reserve hands out the tail
// slot, take hands out the head slot, mark sets or clears a slot's written bit.
// cfg_we/cfg_wdata write the capacity register; write it only while idle.
// The request is held in the EXEC state, whose decision loads the output register.
// A new request is accepted only in the idle state, once the last is decided;
// the transfer reads the written bit from the slot memory (registered read),
// then EXEC decides, writes a mark back and loads the output register.
// The output register holds a result while the receiver stalls; a request can
// still be accepted then, and its decision waits until the register frees.
// Reset clears head, tail and occupancy, loads capacity 4096, then sweeps the
// slot memory to not written, one slot a cycle: in_req.ready stays low until
// the sweep has cleared the last slot.
`default_nettype none

module slot_status_ring_queue import ssrq_pkg::*; #(
  parameter int MAX_SLOTS = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  ssrq_req_if.sink              in_req,
  ssrq_rsp_if.source            out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              val_r, val_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_code_r, out_code_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  head_inc, tail_inc;
  logic              fire;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_rdata;
  logic [1:0]        rd_op;

  ssrq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > MAX_SLOTS) begin
      cap_eff = CNT_W'(MAX_SLOTS);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign head_inc  = CNT_W'(head_r) + CNT_W'(1);
  assign tail_inc  = CNT_W'(tail_r) + CNT_W'(1);
  assign rd_op     = (state_r == ST_IDLE) ? in_req.op : op_r;
  assign mem_raddr = (op_t'(rd_op) == OP_TAKE) ? head_r : tail_r;
  assign fire      = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_code  = out_code_r;
  assign out_rsp.granted_slot = out_slot_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_code_nxt  = out_code_r;
    out_slot_nxt  = out_slot_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(MAX_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.op;
          slot_nxt  = in_req.slot_index;
          val_nxt   = in_req.written_value;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = RC_DONE;
          out_slot_nxt  = '0;
          state_nxt     = ST_IDLE;
          unique case (op_t'(op_r))
            OP_RESERVE: begin
              if (occ_r >= cap_eff) begin
                out_code_nxt = RC_FULL;
              end else if (mem_rdata) begin
                out_code_nxt = RC_TAIL_WRITTEN;
              end else begin
                out_slot_nxt = SLOT_W'(tail_r);
                tail_nxt     = (tail_inc >= cap_eff) ? '0 : IDX_W'(tail_inc);
                occ_nxt      = occ_r + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              if (occ_r == '0) begin
                out_code_nxt = RC_EMPTY;
              end else if (!mem_rdata) begin
                out_code_nxt = RC_HEAD_UNWRITTEN;
              end else begin
                out_slot_nxt = SLOT_W'(head_r);
                head_nxt     = (head_inc >= cap_eff) ? '0 : IDX_W'(head_inc);
                occ_nxt      = occ_r - CNT_W'(1);
              end
            end
            OP_MARK: begin
              out_slot_nxt = slot_r;
              mem_we       = (32'(slot_r) < MAX_SLOTS);
              mem_waddr    = IDX_W'(slot_r);
              mem_wdata    = val_r;
            end
            OP_NOP: begin
              out_slot_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      clr_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    val_r      <= val_nxt;
    out_code_r <= out_code_nxt;
    out_slot_r <= out_slot_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/ssrq_chk.sv
`default_nettype none

module ssrq_chk import ssrq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        result_code,
  input wire logic [SLOT_W-1:0] granted_slot
);

  // the request side is closed right after reset, when the slot sweep starts
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request ready right after reset");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request transfer accepted while another is in flight");

  // refused requests grant no slot
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && result_code != RC_DONE) |-> (granted_slot == '0))
    else $error("refused request carries a slot");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (result_code <= RC_HEAD_UNWRITTEN))
    else $error("result code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_code) && $stable(granted_slot)))
    else $error("stalled result changed");

endmodule

bind slot_status_ring_queue ssrq_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .result_code  (out_rsp.result_code),
  .granted_slot (out_rsp.granted_slot)
);

`default_nettype wire
